/* rtl/assert_macros.svh */
// Assertion helpers used by the RTL. They compile to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

`define ASSERT_CLK_MSG(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop)

`define ASSERT_CLK_MSG(label, clk, rst_n, prop, msg)

`endif

`endif

/* rtl/gsfp_pkg.sv */
package gsfp_pkg;

    // Input command codes. Code 3 carries no meaning and is ignored.
    localparam logic [1:0] CMD_BYTE  = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_HDR   = 2'd1;
    localparam logic [1:0] ST_BAD_SUM   = 2'd2;
    localparam logic [1:0] ST_TIMEOUT   = 2'd3;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_KIND = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS = 1'd1;

    localparam logic [15:0] TIMEOUT_RESET = 16'd500;
    localparam logic        KIND_RESET    = 1'b1;

    localparam logic [7:0] SYNC_BYTE   = 8'hFF;
    localparam logic [7:0] HEADER_BYTE = 8'h86;

    // Position of the checksum byte for each frame length (9 and 11 bytes).
    localparam logic [3:0] SHORT_LAST = 4'd8;
    localparam logic [3:0] LONG_LAST  = 4'd10;

    typedef enum logic {
        CAP_IDLE,
        CAP_ACTIVE
    } t_cap_state;

    typedef struct packed {
        logic             valid;
        logic [1:0]       status;
        logic [3:0][15:0] readings;
    } t_result;

endpackage

/* rtl/gsfp_frame.sv */
module gsfp_frame (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  logic [1:0]          i_command,
    input  logic [7:0]          i_rx_byte,
    input  logic                i_frame_kind,
    input  logic [15:0]         i_timeout_ms,
    output gsfp_pkg::t_result   o_result
);

    gsfp_pkg::t_cap_state r_state, n_state;
    logic [3:0]  r_pos, n_pos;
    logic [7:0]  r_sum, n_sum;
    logic [15:0] r_elapsed, n_elapsed;
    logic        r_hdr_good, n_hdr_good;

    logic [3:0][15:0] r_readings;

    logic        w_rd_we;
    logic [1:0]  w_rd_idx;
    logic [3:0]  w_pos_off;
    logic [15:0] w_elapsed_inc;
    logic [3:0]  w_last;
    logic [7:0]  w_expect;

    assign w_pos_off     = r_pos - 4'd2;
    assign w_rd_idx      = w_pos_off[2:1];
    assign w_elapsed_inc = (r_elapsed == 16'hFFFF) ? r_elapsed : r_elapsed + 16'd1;
    assign w_last        = i_frame_kind ? gsfp_pkg::LONG_LAST : gsfp_pkg::SHORT_LAST;
    assign w_expect      = 8'd0 - r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= gsfp_pkg::CAP_IDLE;
            r_pos      <= 4'd0;
            r_sum      <= 8'd0;
            r_elapsed  <= 16'd0;
            r_hdr_good <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pos      <= n_pos;
            r_sum      <= n_sum;
            r_elapsed  <= n_elapsed;
            r_hdr_good <= n_hdr_good;
        end
    end

    // Even positions start a reading with its high byte; odd ones fill the low byte.
    always_ff @(posedge i_clk) begin
        if (w_rd_we) begin
            if (!r_pos[0]) begin
                r_readings[w_rd_idx] <= {i_rx_byte, 8'h00};
            end else begin
                r_readings[w_rd_idx][7:0] <= i_rx_byte;
            end
        end
    end

    always_comb begin
        n_state         = r_state;
        n_pos           = r_pos;
        n_sum           = r_sum;
        n_elapsed       = r_elapsed;
        n_hdr_good      = r_hdr_good;
        w_rd_we         = 1'b0;
        o_result        = '0;

        if (i_take) begin
            if (i_command == gsfp_pkg::CMD_START) begin
                n_state    = gsfp_pkg::CAP_ACTIVE;
                n_pos      = 4'd0;
                n_sum      = 8'd0;
                n_elapsed  = 16'd0;
                n_hdr_good = 1'b0;
            end else if (r_state == gsfp_pkg::CAP_ACTIVE) begin
                case (i_command)
                    gsfp_pkg::CMD_TICK: begin
                        n_elapsed = w_elapsed_inc;
                        if (w_elapsed_inc >= i_timeout_ms) begin
                            n_state         = gsfp_pkg::CAP_IDLE;
                            o_result.valid  = 1'b1;
                            o_result.status = gsfp_pkg::ST_TIMEOUT;
                        end
                    end
                    gsfp_pkg::CMD_BYTE: begin
                        if (r_pos == 4'd0) begin
                            if (i_rx_byte == gsfp_pkg::SYNC_BYTE) begin
                                n_pos = 4'd1;
                            end
                        end else if (r_pos >= w_last) begin
                            // A shortened frame kind makes any later byte the checksum.
                            n_state        = gsfp_pkg::CAP_IDLE;
                            n_pos          = 4'd0;
                            o_result.valid = 1'b1;
                            if (!r_hdr_good) begin
                                o_result.status = gsfp_pkg::ST_BAD_HDR;
                            end else if (w_expect != i_rx_byte) begin
                                o_result.status = gsfp_pkg::ST_BAD_SUM;
                            end else begin
                                o_result.status      = gsfp_pkg::ST_OK;
                                o_result.readings[0] = r_readings[0];
                                if (i_frame_kind) begin
                                    o_result.readings[1] = r_readings[1];
                                    o_result.readings[2] = r_readings[2];
                                    o_result.readings[3] = r_readings[3];
                                end
                            end
                        end else begin
                            n_sum = r_sum + i_rx_byte;
                            if (r_pos == 4'd1) begin
                                n_hdr_good = (i_rx_byte == gsfp_pkg::HEADER_BYTE);
                            end else begin
                                w_rd_we = 1'b1;
                            end
                            n_pos = r_pos + 4'd1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

/* rtl/gas_sensor_frame_parser.sv */
// Channel   Direction  Handshake                 Payload
// in        request    i_in_valid / o_in_ready   i_command, i_rx_byte
// out       result     o_out_valid / i_out_ready o_status, o_*_reading
// cfg       write      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One request is taken per cycle unless the output stalls; its result, if any, shows in the next cycle.
// The single output register sets the rate: a waiting result blocks a new request
// only while the output is stalled.
// Reset clears the capture state, the output valid and loads the register defaults.
// Configuration writes complete in the cycle they are offered.
`include "assert_macros.svh"

module gas_sensor_frame_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_rx_byte,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [15:0] o_first_reading,
    output logic [15:0] o_second_reading,
    output logic [15:0] o_third_reading,
    output logic [15:0] o_fourth_reading,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [gsfp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic        r_frame_kind;
    logic [15:0] r_timeout_ms;

    logic             r_out_valid;
    logic [1:0]       r_status;
    logic [3:0][15:0] r_readings;

    logic              w_take;
    gsfp_pkg::t_result w_result;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_take      = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_kind <= gsfp_pkg::KIND_RESET;
            r_timeout_ms <= gsfp_pkg::TIMEOUT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                gsfp_pkg::REG_FRAME_KIND: r_frame_kind <= i_cfg_data[0];
                gsfp_pkg::REG_TIMEOUT_MS: r_timeout_ms <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    gsfp_frame u_frame (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (w_take),
        .i_command    (i_command),
        .i_rx_byte    (i_rx_byte),
        .i_frame_kind (r_frame_kind),
        .i_timeout_ms (r_timeout_ms),
        .o_result     (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= w_result.valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_result.valid) begin
            r_status   <= w_result.status;
            r_readings <= w_result.readings;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_first_reading  = r_readings[0];
    assign o_second_reading = r_readings[1];
    assign o_third_reading  = r_readings[2];
    assign o_fourth_reading = r_readings[3];

    `ASSERT_CLK_MSG(a_err_no_data, i_clk, i_rst_n, (o_out_valid && o_status != gsfp_pkg::ST_OK) |-> (o_first_reading == 16'd0 && o_second_reading == 16'd0 && o_third_reading == 16'd0 && o_fourth_reading == 16'd0), "error result carries reading data")
    `ASSERT_CLK_MSG(a_short_frame, i_clk, i_rst_n, (o_out_valid && !r_frame_kind) |-> (o_second_reading == 16'd0 && o_third_reading == 16'd0 && o_fourth_reading == 16'd0), "short frame result carries extra readings")
    `ASSERT_CLK(a_result_cause, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(w_take))

endmodule

/* sim/gas_sensor_frame_parser_tb.sv */
module gas_sensor_frame_parser_tb;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES = 60;
    localparam int BURST_TICKS = 96;

    class parse_scoreboard;
        typedef struct packed {
            logic [1:0]       status;
            logic [3:0][15:0] readings;
        } t_expected;

        t_expected            expected_frames[$];
        logic                 frame_kind;
        logic [15:0]          timeout_ms;
        gsfp_pkg::t_cap_state cap_state;
        logic [3:0]           byte_pos;
        logic [7:0]           sum;
        logic [15:0]          elapsed;
        logic                 header_ok;
        logic [3:0][15:0]     readings;
        int                   mismatches;

        function new();
            frame_kind = gsfp_pkg::KIND_RESET;
            timeout_ms = gsfp_pkg::TIMEOUT_RESET;
            cap_state  = gsfp_pkg::CAP_IDLE;
            byte_pos   = '0;
            sum        = '0;
            elapsed    = '0;
            header_ok  = 1'b0;
            readings   = '0;
            mismatches = 0;
        endfunction

        function void write_register(logic [gsfp_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
            if (idx == gsfp_pkg::REG_FRAME_KIND) begin
                frame_kind = data[0];
            end else if (idx == gsfp_pkg::REG_TIMEOUT_MS) begin
                timeout_ms = data;
            end
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction

        function void note_request(logic [1:0] cmd, logic [7:0] rx);
            t_expected  res;
            logic [3:0] last_pos;
            logic [7:0] want_sum;
            logic [1:0] slot;
            res = '0;
            last_pos = frame_kind ? gsfp_pkg::LONG_LAST : gsfp_pkg::SHORT_LAST;
            if (cmd == gsfp_pkg::CMD_START) begin
                cap_state = gsfp_pkg::CAP_ACTIVE;
                byte_pos  = '0;
                sum       = '0;
                elapsed   = '0;
                header_ok = 1'b0;
                return;
            end
            if (cap_state == gsfp_pkg::CAP_IDLE) return;
            if (cmd == gsfp_pkg::CMD_TICK) begin
                if (elapsed != 16'hFFFF) elapsed++;
                if (elapsed >= timeout_ms) begin
                    cap_state = gsfp_pkg::CAP_IDLE;
                    res.status = gsfp_pkg::ST_TIMEOUT;
                    expected_frames.push_back(res);
                end
            end else if (cmd == gsfp_pkg::CMD_BYTE) begin
                if (byte_pos == 0) begin
                    if (rx == gsfp_pkg::SYNC_BYTE) byte_pos = 4'd1;
                end else if (byte_pos >= last_pos) begin
                    // Whatever byte lands at or past the end is the checksum.
                    cap_state = gsfp_pkg::CAP_IDLE;
                    byte_pos  = '0;
                    want_sum  = 8'h00 - sum;
                    if (!header_ok) begin
                        res.status = gsfp_pkg::ST_BAD_HDR;
                    end else if (want_sum != rx) begin
                        res.status = gsfp_pkg::ST_BAD_SUM;
                    end else begin
                        res.status = gsfp_pkg::ST_OK;
                        res.readings[0] = readings[0];
                        if (frame_kind) res.readings[3:1] = readings[3:1];
                    end
                    expected_frames.push_back(res);
                end else begin
                    sum = sum + rx;
                    if (byte_pos == 1) begin
                        header_ok = (rx == gsfp_pkg::HEADER_BYTE);
                    end else begin
                        slot = 2'((byte_pos - 4'd2) >> 1);
                        if (!byte_pos[0]) begin
                            readings[slot] = {rx, 8'h00};
                        end else begin
                            readings[slot][7:0] = rx;
                        end
                    end
                    byte_pos++;
                end
            end
        endfunction

        function void check_result(logic [1:0] status, logic [3:0][15:0] got);
            t_expected want;
            if (expected_frames.size() == 0) begin
                $display("%0t: expected no result, actual status %0d", $time, status);
                mismatches++;
                return;
            end
            want = expected_frames.pop_front();
            if (status !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, status);
                mismatches++;
            end
            for (int i = 0; i < 4; i++) begin
                if (got[i] !== want.readings[i]) begin
                    $display("%0t: reading %0d expected %h actual %h",
                             $time, i + 1, want.readings[i], got[i]);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_command;
    logic [7:0]  i_rx_byte;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_status;
    logic [15:0] o_first_reading;
    logic [15:0] o_second_reading;
    logic [15:0] o_third_reading;
    logic [15:0] o_fourth_reading;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [gsfp_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [15:0] i_cfg_data;

    parse_scoreboard board = new();
    bit quiet = 1'b0;
    bit hold_request = 1'b0;
    int items_sent = 0;
    int cycle_count = 0;

    gas_sensor_frame_parser dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_command        (i_command),
        .i_rx_byte        (i_rx_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_first_reading  (o_first_reading),
        .o_second_reading (o_second_reading),
        .o_third_reading  (o_third_reading),
        .o_fourth_reading (o_fourth_reading),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            board.check_result(o_status, {o_fourth_reading, o_third_reading,
                                          o_second_reading, o_first_reading});
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Result side: short random stalls, and one long hold when the stimulus asks for it.
    initial begin
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    end

    // Valid stays high after a request is taken; anything that pauses must lower it.
    task automatic send_request(logic [1:0] cmd, logic [7:0] rx);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_rx_byte  <= rx;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_request(cmd, rx);
        items_sent++;
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (board.pending() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(logic [gsfp_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
        wait_for_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_register(idx, data);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_body(int count);
        repeat (count) send_request(gsfp_pkg::CMD_BYTE, pick_byte());
    endtask

    task automatic send_interruption(int pct);
        if ($urandom_range(0, 99) < pct) begin
            send_request($urandom_range(0, 1) ? gsfp_pkg::CMD_TICK : CMD_UNUSED, 8'($urandom));
        end
    endtask

    // fill: 0 random data, 1 all zero, 2 all ones.
    task automatic send_frame(bit hdr_bad, bit sum_bad, int noise, int tick_pct, int fill);
        logic [7:0] hdr;
        logic [7:0] b;
        logic [7:0] sum;
        int data_len;
        data_len = board.frame_kind ? 8 : 6;
        send_request(gsfp_pkg::CMD_START, 8'($urandom));
        repeat (noise) send_request(gsfp_pkg::CMD_BYTE, 8'($urandom_range(0, 254)));
        send_request(gsfp_pkg::CMD_BYTE, gsfp_pkg::SYNC_BYTE);
        hdr = hdr_bad ? gsfp_pkg::HEADER_BYTE ^ 8'($urandom_range(1, 255))
                      : gsfp_pkg::HEADER_BYTE;
        send_interruption(tick_pct);
        send_request(gsfp_pkg::CMD_BYTE, hdr);
        sum = hdr;
        repeat (data_len) begin
            b = (fill == 1) ? 8'h00 : (fill == 2) ? 8'hFF : pick_byte();
            send_interruption(tick_pct);
            send_request(gsfp_pkg::CMD_BYTE, b);
            sum = sum + b;
        end
        b = 8'h00 - sum;
        if (sum_bad) b = b ^ 8'($urandom_range(1, 255));
        send_interruption(tick_pct);
        send_request(gsfp_pkg::CMD_BYTE, b);
    endtask

    task automatic run_random(int count);
        int stop_at;
        int pick;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 9);
            if (pick <= 6) begin
                send_frame($urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0,
                           ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0, 4, 0);
            end else if (pick == 7) begin
                // Perhaps abandoned frame; the next start request restarts the capture.
                send_request(gsfp_pkg::CMD_START, 8'($urandom));
                send_request(gsfp_pkg::CMD_BYTE, gsfp_pkg::SYNC_BYTE);
                send_request(gsfp_pkg::CMD_BYTE, gsfp_pkg::HEADER_BYTE);
                send_body($urandom_range(0, 7));
            end else if (pick == 8) begin
                repeat ($urandom_range(1, 4)) begin
                    send_request(2'($urandom_range(0, 3)), 8'($urandom));
                end
            end else begin
                send_request(gsfp_pkg::CMD_START, 8'($urandom));
                if (board.timeout_ms <= 16'd64) begin
                    repeat (int'(board.timeout_ms) + 1) begin
                        send_request(gsfp_pkg::CMD_TICK, 8'($urandom));
                    end
                end else begin
                    repeat (3) send_request(gsfp_pkg::CMD_TICK, 8'($urandom));
                end
            end
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_command   <= gsfp_pkg::CMD_BYTE;
        i_rx_byte   <= 8'h00;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= gsfp_pkg::REG_FRAME_KIND;
        i_cfg_data  <= 16'h0000;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // An idle block ignores bytes, ticks and the unused command.
        send_request(gsfp_pkg::CMD_BYTE, gsfp_pkg::SYNC_BYTE);
        send_request(gsfp_pkg::CMD_TICK, 8'h00);
        send_request(CMD_UNUSED, 8'hA5);
        send_frame(1'b0, 1'b0, 1, 0, 2);
        write_register(gsfp_pkg::REG_FRAME_KIND, 16'h0000);
        send_frame(1'b1, 1'b1, 0, 0, 1);

        // Frame length switched while a capture is in progress, both ways.
        send_request(gsfp_pkg::CMD_START, 8'h00);
        send_request(gsfp_pkg::CMD_BYTE, gsfp_pkg::SYNC_BYTE);
        send_request(gsfp_pkg::CMD_BYTE, gsfp_pkg::HEADER_BYTE);
        send_body(3);
        write_register(gsfp_pkg::REG_FRAME_KIND, 16'h0001);
        send_body(6);
        send_request(gsfp_pkg::CMD_START, 8'h00);
        send_request(gsfp_pkg::CMD_BYTE, gsfp_pkg::SYNC_BYTE);
        send_request(gsfp_pkg::CMD_BYTE, gsfp_pkg::HEADER_BYTE);
        send_body(7);
        write_register(gsfp_pkg::REG_FRAME_KIND, 16'h0000);
        send_body(1);

        wait_for_results();
        hold_request = 1'b1;
        run_random(250);

        write_register(gsfp_pkg::REG_TIMEOUT_MS, 16'd1);
        hold_request = 1'b1;
        run_random(250);

        write_register(gsfp_pkg::REG_FRAME_KIND, 16'h0001);
        write_register(gsfp_pkg::REG_TIMEOUT_MS, 16'd0);
        run_random(200);

        // A long timeout, reached with a solid burst of ticks.
        write_register(gsfp_pkg::REG_TIMEOUT_MS, 16'(BURST_TICKS));
        quiet = 1'b1;
        send_request(gsfp_pkg::CMD_START, 8'h00);
        repeat (BURST_TICKS) send_request(gsfp_pkg::CMD_TICK, 8'h00);
        quiet = 1'b0;
        run_random(250);

        write_register(gsfp_pkg::REG_FRAME_KIND, 16'h0000);
        write_register(gsfp_pkg::REG_TIMEOUT_MS, 16'($urandom_range(2, 60)));
        run_random(300);

        write_register(gsfp_pkg::REG_FRAME_KIND, 16'h0001);
        write_register(gsfp_pkg::REG_TIMEOUT_MS, gsfp_pkg::TIMEOUT_RESET);
        quiet = 1'b1;
        run_random(350);

        wait_for_results();
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
